// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the router RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_RST(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/core/gar_pkg.sv =====
// Types, constants and helper functions of the geometry attribute router.
`default_nettype none
package gar_pkg;

    // Register file sizes of the geometry shader
    localparam int UNIFORM_REGS = 96;
    localparam int INPUT_REGS   = 16;

    // Write pointer must hold UNIFORM_REGS itself
    localparam int WP_W  = $clog2(UNIFORM_REGS + 1);
    localparam int CMP_W = WP_W + 2;

    // Command queue depth between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [2:0] CFG_GS_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_GS_MODE      = 3'd1;
    localparam logic [2:0] CFG_VS_OUT_COUNT = 3'd2;
    localparam logic [2:0] CFG_GS_IN_COUNT  = 3'd3;
    localparam logic [2:0] CFG_MAIN_VERTS   = 3'd4;
    localparam logic [2:0] CFG_FIXED_VERTS  = 3'd5;
    localparam logic [2:0] CFG_FIXED_START  = 3'd6;

    // Geometry modes
    localparam logic [1:0] MODE_POINT    = 2'd0;
    localparam logic [1:0] MODE_VARIABLE = 2'd1;
    localparam logic [1:0] MODE_FIXED    = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    typedef enum logic [1:0] {
        DEST_GS_IN   = 2'd0,
        DEST_UNIFORM = 2'd1,
        DEST_PRIM    = 2'd2
    } t_dest;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNEXPECTED = 2'd1,
        ST_OVERFLOW   = 2'd2
    } t_status;

    // One classified item travelling from front to back
    typedef struct packed {
        logic        write_valid;
        t_dest       dest;
        logic [6:0]  reg_number;
        logic        use_count;
        logic [7:0]  index_value;
        logic [23:0] comp_x;
        logic [23:0] comp_y;
        logic [23:0] comp_z;
        logic [23:0] comp_w;
        logic        invoke;
        t_status     status;
    } t_cmd;

    // Convert a vertex count to float24
    function automatic logic [23:0] count_to_f24(input logic [7:0] v);
        logic [2:0]  e;
        logic [7:0]  rest;
        logic [23:0] shifted;
        e = '0;
        for (int k = 1; k < 8; k++) begin
            if (v[k]) begin
                e = 3'(k);
            end
        end
        rest    = v ^ (8'd1 << e);
        shifted = {rest, 16'd0} >> e;
        if (v == 8'd0) begin
            return 24'd0;
        end
        return {1'b0, 7'(e) + 7'd63, shifted[15:0]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gar_front.sv =====
// Front end: configuration registers, routing state and item classification.
`default_nettype none
`include "assert_macros.svh"
module gar_front import gar_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_index_value,
    input  wire logic [23:0] i_comp_x,
    input  wire logic [23:0] i_comp_y,
    input  wire logic [23:0] i_comp_z,
    input  wire logic [23:0] i_comp_w,
    input  wire logic        i_vertex_end,
    output t_cmd             o_cmd,
    output logic             o_cmd_push
);

    logic            r_en;
    logic [1:0]      r_mode;
    logic [4:0]      r_vs_count;
    logic [4:0]      r_gs_in_count;
    logic [8:0]      r_main_count;
    logic [6:0]      r_fixed_count;
    logic [6:0]      r_fixed_start;

    logic [WP_W-1:0] r_wp, n_wp;
    logic [4:0]      r_attr_pos, n_attr_pos;
    logic [8:0]      r_main_left, n_main_left;
    logic [7:0]      r_vleft, n_vleft;
    logic            r_awaiting, n_awaiting;

    logic            accept;
    logic            cfg_hit;
    logic [4:0]      vs_eff;
    logic            excess;
    logic [5:0]      lim;
    logic [5:0]      gs_in_ext;
    logic [6:0]      fv;
    logic [11:0]     total;
    logic [7:0]      fixed_reg;
    logic [WP_W-1:0] wp_inc;
    logic [7:0]      vleft_dec;
    t_cmd            cmd;

    assign accept = i_push && !i_full;
    assign cfg_hit = i_cfg_we && (i_cfg_index <= CFG_FIXED_START);

    // Derive effective counts from configuration
    always_comb begin
        if (r_vs_count == 5'd0) begin
            vs_eff = 5'd1;
        end else if (r_vs_count > 5'd16) begin
            vs_eff = 5'd16;
        end else begin
            vs_eff = r_vs_count;
        end
        gs_in_ext = (r_gs_in_count == 5'd0) ? 6'd1 : {1'b0, r_gs_in_count};
        lim = (gs_in_ext > 6'(INPUT_REGS)) ? 6'(INPUT_REGS) : gs_in_ext;
        fv = (r_fixed_count == 7'd0) ? 7'd1 : r_fixed_count;
        total = 12'(vs_eff) * 12'(fv);
    end

    assign excess    = r_attr_pos >= vs_eff;
    assign fixed_reg = 8'(r_fixed_start) + 8'(r_wp);
    assign wp_inc    = r_wp + WP_W'(1);
    assign vleft_dec = (r_vleft != 8'd0) ? r_vleft - 8'd1 : 8'd0;

    // Classify the beat and compute the next routing state
    always_comb begin
        cmd             = '0;
        cmd.index_value = i_index_value;
        cmd.comp_x      = i_comp_x;
        cmd.comp_y      = i_comp_y;
        cmd.comp_z      = i_comp_z;
        cmd.comp_w      = i_comp_w;
        n_wp            = r_wp;
        n_attr_pos      = r_attr_pos;
        n_main_left     = r_main_left;
        n_vleft         = r_vleft;
        n_awaiting      = r_awaiting;

        if (r_en && r_mode == MODE_UNUSED) begin
            cmd.status = ST_UNEXPECTED;
        end else if (i_func) begin
            if (!r_en || r_mode != MODE_VARIABLE || !r_awaiting) begin
                cmd.status = ST_UNEXPECTED;
            end else if (i_index_value == 8'd0) begin
                cmd.status = ST_OVERFLOW;
            end else begin
                cmd.write_valid = 1'b1;
                cmd.dest        = DEST_UNIFORM;
                cmd.use_count   = 1'b1;
                n_wp            = WP_W'(1);
                n_main_left     = (r_main_count == 9'd0) ? 9'd1 : r_main_count;
                n_vleft         = i_index_value;
                n_awaiting      = 1'b0;
            end
        end else if (r_en && r_mode == MODE_VARIABLE && r_awaiting) begin
            cmd.status = ST_UNEXPECTED;
        end else begin
            // Track the attribute position within the vertex
            if (i_vertex_end) begin
                n_attr_pos = 5'd0;
            end else if (r_attr_pos < 5'd31) begin
                n_attr_pos = r_attr_pos + 5'd1;
            end

            if (!r_en) begin
                if (excess) begin
                    cmd.status = ST_UNEXPECTED;
                end else begin
                    cmd.write_valid = 1'b1;
                    cmd.dest        = DEST_PRIM;
                    cmd.reg_number  = 7'(r_attr_pos);
                end
            end else begin
                case (r_mode)
                    MODE_POINT: begin
                        if (excess) begin
                            cmd.status = ST_UNEXPECTED;
                        end else if (CMP_W'(r_wp) >= CMP_W'(lim)) begin
                            n_wp       = '0;
                            cmd.status = ST_OVERFLOW;
                        end else begin
                            cmd.write_valid = 1'b1;
                            cmd.dest        = DEST_GS_IN;
                            cmd.reg_number  = 7'(r_wp);
                            n_wp            = wp_inc;
                            if (CMP_W'(wp_inc) >= CMP_W'(lim)) begin
                                n_wp       = '0;
                                cmd.invoke = 1'b1;
                            end
                        end
                    end
                    MODE_FIXED: begin
                        if (excess) begin
                            cmd.status = ST_UNEXPECTED;
                        end else if (fixed_reg >= 8'(UNIFORM_REGS)) begin
                            cmd.status = ST_OVERFLOW;
                        end else begin
                            cmd.write_valid = 1'b1;
                            cmd.dest        = DEST_UNIFORM;
                            cmd.reg_number  = 7'(fixed_reg);
                            n_wp            = wp_inc;
                            if (12'(wp_inc) >= total) begin
                                n_wp       = '0;
                                cmd.invoke = 1'b1;
                            end
                        end
                    end
                    default: begin
                        // Variable mode with an open batch
                        if (excess) begin
                            cmd.status = ST_UNEXPECTED;
                        end else if (r_main_left != 9'd0 || r_attr_pos == 5'd0) begin
                            if (CMP_W'(r_wp) >= CMP_W'(UNIFORM_REGS)) begin
                                cmd.status = ST_OVERFLOW;
                            end else begin
                                cmd.write_valid = 1'b1;
                                cmd.dest        = DEST_UNIFORM;
                                cmd.reg_number  = 7'(r_wp);
                                n_wp            = wp_inc;
                            end
                        end
                        if (i_vertex_end) begin
                            if (r_main_left != 9'd0) begin
                                n_main_left = r_main_left - 9'd1;
                            end
                            n_vleft = vleft_dec;
                            if (vleft_dec == 8'd0) begin
                                n_awaiting = 1'b1;
                                cmd.invoke = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Hold configuration; a write to a defined index restarts routing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en          <= 1'b0;
            r_mode        <= MODE_POINT;
            r_vs_count    <= 5'd1;
            r_gs_in_count <= 5'd16;
            r_main_count  <= 9'd1;
            r_fixed_count <= 7'd1;
            r_fixed_start <= 7'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GS_ENABLE:    r_en          <= i_cfg_data[0];
                CFG_GS_MODE:      r_mode        <= i_cfg_data[1:0];
                CFG_VS_OUT_COUNT: r_vs_count    <= i_cfg_data[4:0];
                CFG_GS_IN_COUNT:  r_gs_in_count <= i_cfg_data[4:0];
                CFG_MAIN_VERTS:   r_main_count  <= i_cfg_data;
                CFG_FIXED_VERTS:  r_fixed_count <= i_cfg_data[6:0];
                CFG_FIXED_START:  r_fixed_start <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Advance routing state on each accepted beat; reset or a configuration write restarts it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_wp        <= '0;
            r_attr_pos  <= 5'd0;
            r_main_left <= 9'd0;
            r_vleft     <= 8'd0;
            r_awaiting  <= 1'b1;
        end else if (accept) begin
            r_wp        <= n_wp;
            r_attr_pos  <= n_attr_pos;
            r_main_left <= n_main_left;
            r_vleft     <= n_vleft;
            r_awaiting  <= n_awaiting;
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = accept;

    `ASSERT_RST(a_write_ok, (accept && cmd.write_valid) |-> (cmd.status == ST_OK))
    `ASSERT_RST(a_drop_clean,
        (accept && !cmd.write_valid) |-> (cmd.reg_number == 7'd0 && cmd.dest == DEST_GS_IN))
    `ASSERT_ALWAYS(a_cfg_rearm, cfg_hit |=> (r_awaiting && r_wp == '0))

endmodule
`default_nettype wire

// ===== rtl/core/gar_cmd_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
`include "assert_macros.svh"
module gar_cmd_queue import gar_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_data,
    input  wire logic i_pop
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `ASSERT_RST(a_cnt_range, r_count <= QCNT_W'(QDEPTH))
    `ASSERT_RST(a_ptr_gap,
        (r_count == '0 || r_count == QCNT_W'(QDEPTH)) |-> (r_wr_ptr == r_rd_ptr))

endmodule
`default_nettype wire

// ===== rtl/core/gar_back.sv =====
// Back end: forms the result beat and holds it in the output register.
`default_nettype none
module gar_back import gar_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_valid,
    output t_cmd      o_res,
    input  wire logic i_pop
);

    logic        r_valid;
    t_cmd        r_res;
    t_cmd        res;
    logic [23:0] f24;
    logic        take;

    assign f24  = count_to_f24(i_cmd.index_value);
    assign take = i_cmd_valid && (!r_valid || i_pop);

    // Select written data or the float24 vertex count; dropped beats carry zero data
    always_comb begin
        res = i_cmd;
        if (!i_cmd.write_valid) begin
            res.comp_x = '0;
            res.comp_y = '0;
            res.comp_z = '0;
            res.comp_w = '0;
        end else if (i_cmd.use_count) begin
            res.comp_x = f24;
            res.comp_y = f24;
            res.comp_z = f24;
            res.comp_w = f24;
        end
    end

    // Load the output register when it is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign o_cmd_pop = take;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

endmodule
`default_nettype wire

// ===== rtl/core/geometry_attribute_router.sv =====
// Geometry attribute router top level.
// Input channel: drive push with one attribute or index beat; it is taken at a
// clock edge where push is high and full is low. Result channel: while empty
// is low the oldest result is on the o_ result ports; pop at an edge where
// empty is low takes it. Every input beat yields exactly one result beat.
// Configuration: a write through i_cfg_we / i_cfg_index / i_cfg_data to index
// 0 to 6 is registered and restarts the routing counters; write only while idle.
// The front end classifies each input beat and updates its counters in the
// cycle of acceptance and writes its command into the queue; the back end then
// moves the command into the output register. Throughput is one beat per cycle
// while full is low, since the front end updates its counters on each beat.
// A four-entry command queue sits between front and back, so input keeps
// flowing while the result side stalls until the queue and output register
// fill; full then rises. Reset (i_rst_n low, synchronous) empties the queue,
// marks the output register empty and loads the default configuration.
`default_nettype none
module geometry_attribute_router import gar_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_index_value,
    input  wire logic [23:0] i_comp_x,
    input  wire logic [23:0] i_comp_y,
    input  wire logic [23:0] i_comp_z,
    input  wire logic [23:0] i_comp_w,
    input  wire logic        i_vertex_end,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_write_valid,
    output logic [1:0]       o_destination,
    output logic [6:0]       o_reg_number,
    output logic [23:0]      o_out_x,
    output logic [23:0]      o_out_y,
    output logic [23:0]      o_out_z,
    output logic [23:0]      o_out_w,
    output logic             o_invoke_shader,
    output logic [1:0]       o_status
);

    t_cmd front_cmd;
    logic front_push;
    logic q_full;
    logic q_valid;
    t_cmd q_data;
    logic q_pop;
    logic out_valid;
    t_cmd out_res;

    gar_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (q_full),
        .i_func        (i_func),
        .i_index_value (i_index_value),
        .i_comp_x      (i_comp_x),
        .i_comp_y      (i_comp_y),
        .i_comp_z      (i_comp_z),
        .i_comp_w      (i_comp_w),
        .i_vertex_end  (i_vertex_end),
        .o_cmd         (front_cmd),
        .o_cmd_push    (front_push)
    );

    gar_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    gar_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_data),
        .o_cmd_pop   (q_pop),
        .o_valid     (out_valid),
        .o_res       (out_res),
        .i_pop       (pop)
    );

    // Drive the result ports from the output register
    assign full            = q_full;
    assign empty           = !out_valid;
    assign o_write_valid   = out_res.write_valid;
    assign o_destination   = out_res.dest;
    assign o_reg_number    = out_res.reg_number;
    assign o_out_x         = out_res.comp_x;
    assign o_out_y         = out_res.comp_y;
    assign o_out_z         = out_res.comp_z;
    assign o_out_w         = out_res.comp_w;
    assign o_invoke_shader = out_res.invoke;
    assign o_status        = out_res.status;

endmodule
`default_nettype wire

// ===== test/geometry_attribute_router_checker.sv =====
// Checker for the geometry attribute router: predicts each routed write and compares results.
module geometry_attribute_router_checker import gar_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_index_value,
    input  wire logic [23:0] i_comp_x,
    input  wire logic [23:0] i_comp_y,
    input  wire logic [23:0] i_comp_z,
    input  wire logic [23:0] i_comp_w,
    input  wire logic        i_vertex_end,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic        i_write_valid,
    input  wire logic [1:0]  i_destination,
    input  wire logic [6:0]  i_reg_number,
    input  wire logic [23:0] i_out_x,
    input  wire logic [23:0] i_out_y,
    input  wire logic [23:0] i_out_z,
    input  wire logic [23:0] i_out_w,
    input  wire logic        i_invoke_shader,
    input  wire logic [1:0]  i_status,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic        write_valid;
        t_dest       dest;
        logic [6:0]  reg_num;
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        logic [23:0] w;
        logic        invoke;
        t_status     status;
    } t_route_write;

    // Configuration copy
    logic       cfg_enable;
    logic [1:0] cfg_mode;
    logic [4:0] cfg_vs_count;
    logic [4:0] cfg_in_count;
    logic [8:0] cfg_main_verts;
    logic [6:0] cfg_fixed_verts;
    logic [6:0] cfg_fixed_start;

    // Routing counters
    int   wr_ptr;
    int   attr_pos;
    int   mains_left;
    int   verts_left;
    logic want_index;

    t_route_write expected_writes[$];

    task automatic restart_routing();
        wr_ptr     = 0;
        attr_pos   = 0;
        mains_left = 0;
        verts_left = 0;
        want_index = 1'b1;
    endtask

    // Encode a small vertex count as float24: bias 63, 16-bit fraction
    function automatic logic [23:0] count_as_float24(input logic [7:0] n);
        int          msb;
        logic [15:0] frac;
        msb = 0;
        for (int b = 7; b >= 1; b--) begin
            if (n[b] && msb == 0) begin
                msb = b;
            end
        end
        if (n == 8'd0) begin
            return 24'd0;
        end
        frac = 16'((32'(n) & ~(32'd1 << msb)) << (16 - msb));
        return {1'b0, 7'(msb + 63), frac};
    endfunction

    function automatic t_route_write routed_write(input t_dest d, input int reg_idx,
                                                  input logic [23:0] x, input logic [23:0] y,
                                                  input logic [23:0] z, input logic [23:0] w);
        t_route_write r;
        r             = '0;
        r.write_valid = 1'b1;
        r.dest        = d;
        r.reg_num     = 7'(reg_idx);
        r.x           = x;
        r.y           = y;
        r.z           = z;
        r.w           = w;
        r.status      = ST_OK;
        return r;
    endfunction

    // Route one accepted beat and advance the counters
    function automatic t_route_write route_beat(input logic func, input logic [7:0] ival,
                                                input logic [23:0] x, input logic [23:0] y,
                                                input logic [23:0] z, input logic [23:0] w,
                                                input logic vend);
        t_route_write r;
        int           vs_eff;
        int           fill;
        int           pos;
        int           total;
        int           target;
        logic         excess;
        logic [23:0]  cnt;
        r        = '0;
        r.dest   = DEST_GS_IN;
        r.status = ST_OK;
        vs_eff   = (cfg_vs_count == 0) ? 1 : ((cfg_vs_count > 16) ? 16 : int'(cfg_vs_count));
        pos      = attr_pos;
        excess   = attr_pos >= vs_eff;

        if (cfg_enable && cfg_mode == MODE_UNUSED) begin
            r.status = ST_UNEXPECTED;
            return r;
        end

        // Vertex-count index beat
        if (func) begin
            if (!cfg_enable || cfg_mode != MODE_VARIABLE || !want_index) begin
                r.status = ST_UNEXPECTED;
            end else if (ival == 8'd0) begin
                r.status = ST_OVERFLOW;
            end else begin
                cnt        = count_as_float24(ival);
                r          = routed_write(DEST_UNIFORM, 0, cnt, cnt, cnt, cnt);
                wr_ptr     = 1;
                mains_left = (cfg_main_verts == 0) ? 1 : int'(cfg_main_verts);
                verts_left = int'(ival);
                want_index = 1'b0;
            end
            return r;
        end

        if (cfg_enable && cfg_mode == MODE_VARIABLE && want_index) begin
            r.status = ST_UNEXPECTED;
            return r;
        end

        if (vend) begin
            attr_pos = 0;
        end else if (attr_pos < 31) begin
            attr_pos++;
        end

        // Pass-through to primitive assembly
        if (!cfg_enable) begin
            if (excess) begin
                r.status = ST_UNEXPECTED;
            end else begin
                r = routed_write(DEST_PRIM, pos, x, y, z, w);
            end
            return r;
        end

        // Point mode: fill input registers
        if (cfg_mode == MODE_POINT) begin
            fill = (cfg_in_count == 0) ? 1 : int'(cfg_in_count);
            if (fill > INPUT_REGS) begin
                fill = INPUT_REGS;
            end
            if (excess) begin
                r.status = ST_UNEXPECTED;
            end else if (wr_ptr >= fill) begin
                wr_ptr   = 0;
                r.status = ST_OVERFLOW;
            end else begin
                r = routed_write(DEST_GS_IN, wr_ptr, x, y, z, w);
                wr_ptr++;
                if (wr_ptr >= fill) begin
                    wr_ptr   = 0;
                    r.invoke = 1'b1;
                end
            end
            return r;
        end

        // Fixed mode: uniforms from the start register
        if (cfg_mode == MODE_FIXED) begin
            total  = vs_eff * ((cfg_fixed_verts == 0) ? 1 : int'(cfg_fixed_verts));
            target = int'(cfg_fixed_start) + wr_ptr;
            if (excess) begin
                r.status = ST_UNEXPECTED;
            end else if (target >= UNIFORM_REGS) begin
                r.status = ST_OVERFLOW;
            end else begin
                r = routed_write(DEST_UNIFORM, target, x, y, z, w);
                wr_ptr++;
                if (wr_ptr >= total) begin
                    wr_ptr   = 0;
                    r.invoke = 1'b1;
                end
            end
            return r;
        end

        // Variable mode with an open batch
        if (excess) begin
            r.status = ST_UNEXPECTED;
        end else if (mains_left != 0 || pos == 0) begin
            if (wr_ptr >= UNIFORM_REGS) begin
                r.status = ST_OVERFLOW;
            end else begin
                r = routed_write(DEST_UNIFORM, wr_ptr, x, y, z, w);
                wr_ptr++;
            end
        end
        if (vend) begin
            if (mains_left != 0) begin
                mains_left--;
            end
            if (verts_left != 0) begin
                verts_left--;
            end
            if (verts_left == 0) begin
                want_index = 1'b1;
                r.invoke   = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [23:0] got,
                                   input logic [23:0] exp_v);
        $display("%0t: %s mismatch, got %0h, expected %0h", $realtime, field, got, exp_v);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Track config writes, predict accepted beats, check popped results
    always @(posedge i_clk) begin : watch
        t_route_write exp_w;
        if (!i_rst_n) begin
            cfg_enable      = 1'b0;
            cfg_mode        = MODE_POINT;
            cfg_vs_count    = 5'd1;
            cfg_in_count    = 5'd16;
            cfg_main_verts  = 9'd1;
            cfg_fixed_verts = 7'd1;
            cfg_fixed_start = 7'd0;
            restart_routing();
            expected_writes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GS_ENABLE:    cfg_enable      = i_cfg_data[0];
                    CFG_GS_MODE:      cfg_mode        = i_cfg_data[1:0];
                    CFG_VS_OUT_COUNT: cfg_vs_count    = i_cfg_data[4:0];
                    CFG_GS_IN_COUNT:  cfg_in_count    = i_cfg_data[4:0];
                    CFG_MAIN_VERTS:   cfg_main_verts  = i_cfg_data[8:0];
                    CFG_FIXED_VERTS:  cfg_fixed_verts = i_cfg_data[6:0];
                    CFG_FIXED_START:  cfg_fixed_start = i_cfg_data[6:0];
                    default: ;
                endcase
                if (i_cfg_index <= CFG_FIXED_START) begin
                    restart_routing();
                end
            end
            if (push && !full) begin
                expected_writes.push_back(route_beat(i_func, i_index_value, i_comp_x,
                                                     i_comp_y, i_comp_z, i_comp_w,
                                                     i_vertex_end));
            end
            if (pop && !empty) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("unexpected result beat", 24'd0, 24'd0);
                end else begin
                    exp_w = expected_writes.pop_front();
                    if (i_write_valid !== exp_w.write_valid)
                        report_mismatch("write_valid", 24'(i_write_valid),
                                        24'(exp_w.write_valid));
                    if (i_destination !== exp_w.dest)
                        report_mismatch("destination", 24'(i_destination), 24'(exp_w.dest));
                    if (i_reg_number !== exp_w.reg_num)
                        report_mismatch("reg_number", 24'(i_reg_number), 24'(exp_w.reg_num));
                    if (i_out_x !== exp_w.x)
                        report_mismatch("out_x", i_out_x, exp_w.x);
                    if (i_out_y !== exp_w.y)
                        report_mismatch("out_y", i_out_y, exp_w.y);
                    if (i_out_z !== exp_w.z)
                        report_mismatch("out_z", i_out_z, exp_w.z);
                    if (i_out_w !== exp_w.w)
                        report_mismatch("out_w", i_out_w, exp_w.w);
                    if (i_invoke_shader !== exp_w.invoke)
                        report_mismatch("invoke_shader", 24'(i_invoke_shader),
                                        24'(exp_w.invoke));
                    if (i_status !== exp_w.status)
                        report_mismatch("status", 24'(i_status), 24'(exp_w.status));
                end
            end
        end
        o_pending = expected_writes.size();
    end

endmodule

// ===== test/geometry_attribute_router_tb.sv =====
// Testbench top for the geometry attribute router: stimulus, handshakes and verdict.
module geometry_attribute_router_tb import gar_pkg::*;;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;
    logic        push;
    logic        full;
    logic        i_func;
    logic [7:0]  i_index_value;
    logic [23:0] i_comp_x;
    logic [23:0] i_comp_y;
    logic [23:0] i_comp_z;
    logic [23:0] i_comp_w;
    logic        i_vertex_end;
    logic        empty;
    logic        pop;
    logic        o_write_valid;
    logic [1:0]  o_destination;
    logic [6:0]  o_reg_number;
    logic [23:0] o_out_x;
    logic [23:0] o_out_y;
    logic [23:0] o_out_z;
    logic [23:0] o_out_w;
    logic        o_invoke_shader;
    logic [1:0]  o_status;

    int         fail_count;
    int         pending;
    int         beats_sent;
    int         phase_end;
    bit         calm;
    int         cur_vs;
    logic       cur_en;
    logic [1:0] cur_mode;

    geometry_attribute_router dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_func          (i_func),
        .i_index_value   (i_index_value),
        .i_comp_x        (i_comp_x),
        .i_comp_y        (i_comp_y),
        .i_comp_z        (i_comp_z),
        .i_comp_w        (i_comp_w),
        .i_vertex_end    (i_vertex_end),
        .empty           (empty),
        .pop             (pop),
        .o_write_valid   (o_write_valid),
        .o_destination   (o_destination),
        .o_reg_number    (o_reg_number),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_out_w         (o_out_w),
        .o_invoke_shader (o_invoke_shader),
        .o_status        (o_status)
    );

    geometry_attribute_router_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_func          (i_func),
        .i_index_value   (i_index_value),
        .i_comp_x        (i_comp_x),
        .i_comp_y        (i_comp_y),
        .i_comp_z        (i_comp_z),
        .i_comp_w        (i_comp_w),
        .i_vertex_end    (i_vertex_end),
        .empty           (empty),
        .pop             (pop),
        .i_write_valid   (o_write_valid),
        .i_destination   (o_destination),
        .i_reg_number    (o_reg_number),
        .i_out_x         (o_out_x),
        .i_out_y         (o_out_y),
        .i_out_z         (o_out_z),
        .i_out_w         (o_out_w),
        .i_invoke_shader (o_invoke_shader),
        .i_status        (o_status),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop for a hung handshake
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: pop with random stall bursts, none once calm
    initial begin : pop_drive
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                pop <= 1'b1;
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 9) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [23:0] rand_comp();
        case ($urandom_range(0, 3))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    // Pick an extreme or an in-range value; small values favored when asked
    function automatic int pick(input int lo, input int hi, input bit favor_small);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return lo;
        if (r == 1) return hi;
        if (favor_small) return $urandom_range(lo, (hi < lo + 4) ? hi : lo + 4);
        return $urandom_range(lo, hi);
    endfunction

    // Offer one beat, with an optional idle burst ahead of it; hold until taken
    task automatic send_beat(input logic func, input logic [7:0] ival,
                             input logic [23:0] x, input logic [23:0] y,
                             input logic [23:0] z, input logic [23:0] w, input logic vend);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
        end
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push          <= 1'b1;
        i_func        <= func;
        i_index_value <= ival;
        i_comp_x      <= x;
        i_comp_y      <= y;
        i_comp_z      <= z;
        i_comp_w      <= w;
        i_vertex_end  <= vend;
        do @(posedge i_clk); while (full);
        beats_sent++;
    endtask

    task automatic send_attr(input logic vend);
        send_beat(1'b0, 8'($urandom()), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  vend);
    endtask

    task automatic send_index(input logic [7:0] count);
        send_beat(1'b1, count, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  1'($urandom()));
    endtask

    task automatic send_noise();
        send_beat(1'($urandom()), 8'($urandom()), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), 1'($urandom()));
    endtask

    task automatic send_vertex(input int n);
        for (int k = 0; k < n; k++) begin
            send_attr(k == n - 1);
        end
    endtask

    // Mostly complete vertices, some short, some with excess attributes
    function automatic int vertex_len();
        int r;
        r = $urandom_range(0, 11);
        if (r < 8) return cur_vs;
        if (r < 10) return $urandom_range(1, cur_vs);
        if (r == 10) return cur_vs + $urandom_range(1, 2);
        return $urandom_range(cur_vs + 1, 34);
    endfunction

    // Drop push and wait for every expected result
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [2:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 9'(data);
    endtask

    task automatic configure(input logic en, input logic [1:0] mode, input int vs,
                             input int gs_in, input int mains, input int fverts,
                             input int fstart);
        settle();
        cfg_write(CFG_GS_ENABLE, en);
        cfg_write(CFG_GS_MODE, mode);
        cfg_write(CFG_VS_OUT_COUNT, vs);
        cfg_write(CFG_GS_IN_COUNT, gs_in);
        cfg_write(CFG_MAIN_VERTS, mains);
        cfg_write(CFG_FIXED_VERTS, fverts);
        cfg_write(CFG_FIXED_START, fstart);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_en   = en;
        cur_mode = mode;
        cur_vs   = vs;
    endtask

    // One variable-mode batch: index beat, then up to its count of vertices
    task automatic run_batch();
        int count;
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
        send_index(8'(count));
        for (int v = 0; v < count && beats_sent < phase_end; v++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_noise();
            end
            send_vertex(vertex_len());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_GS_ENABLE;
        i_cfg_data    = '0;
        push          = 1'b0;
        i_func        = 1'b0;
        i_index_value = '0;
        i_comp_x      = '0;
        i_comp_y      = '0;
        i_comp_z      = '0;
        i_comp_w      = '0;
        i_vertex_end  = 1'b0;
        beats_sent    = 0;
        phase_end     = 0;
        calm          = 1'b0;
        cur_en        = 1'b0;
        cur_mode      = MODE_POINT;
        cur_vs        = 1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: pass-through, one attribute per vertex
        send_beat(1'b0, 8'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        send_beat(1'b0, 8'hFF, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
        send_attr(1'b1);
        send_index(8'd5);

        // Variable mode: stray attribute, zero count, batch of two, repeated index
        configure(1'b1, MODE_VARIABLE, 2, 16, 1, 1, 0);
        send_attr(1'b1);
        send_index(8'd0);
        send_index(8'd2);
        send_index(8'd3);
        send_vertex(2);
        send_vertex(3);
        send_index(8'd255);

        // Fixed mode at the last uniform, then overflow
        configure(1'b1, MODE_FIXED, 1, 16, 1, 2, 95);
        send_attr(1'b1);
        send_attr(1'b1);

        // Point mode with a single-register fill, then a four-register fill
        configure(1'b1, MODE_POINT, 1, 1, 1, 1, 0);
        send_attr(1'b1);
        send_index(8'd1);
        configure(1'b1, MODE_POINT, 4, 4, 1, 1, 0);
        send_vertex(4);

        // Random phases, each under a fresh configuration
        while (beats_sent < 1200) begin
            if (beats_sent > 1000) begin
                calm = 1'b1;
            end
            configure($urandom_range(0, 5) != 0, 2'($urandom_range(0, 2)), pick(1, 16, 1'b0),
                      pick(1, 16, 1'b0), pick(1, 256, 1'b1), pick(1, 96, 1'b1),
                      pick(0, 95, 1'b0));
            phase_end = beats_sent + $urandom_range(30, 100);
            while (beats_sent < phase_end) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_noise();
                end else if (cur_en && cur_mode == MODE_VARIABLE) begin
                    run_batch();
                end else begin
                    send_vertex(vertex_len());
                end
            end
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== geometry_attribute_router.f =====
+incdir+rtl/core
rtl/core/gar_pkg.sv
rtl/core/gar_front.sv
rtl/core/gar_cmd_queue.sv
rtl/core/gar_back.sv
rtl/core/geometry_attribute_router.sv
test/geometry_attribute_router_checker.sv
test/geometry_attribute_router_tb.sv
